// File: sv/nlms_pkg.sv
// Shared types and constants for the normalized LMS predictor.
`timescale 1ns / 1ps
package nlms_pkg;
  localparam int unsigned SampleW = 16;
  localparam int unsigned WeightW = 32;
  localparam logic signed [31:0] ThreshReset = 32'sh0100_0000;
  localparam logic [31:0] GoalReset = 32'd3277;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROTATE,
    ST_DIV,
    ST_UPDATE,
    ST_FINISH,
    ST_OUT
  } state_e;

  // Control from sequencer to the cell chain.
  typedef struct packed {
    logic clear;     // epoch start: zero samples
    logic rotate;    // circulate one step, accumulate
    logic update;    // circulate one step, apply weight step
    logic shift_in;  // push the new sample
  } cell_ctl_t;
endpackage

// File: sv/nlms_cell.sv
// One predictor tap: holds a sample and its weight, passes both to its neighbor.
`timescale 1ns / 1ps
module nlms_cell
  import nlms_pkg::*;
(
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  cell_ctl_t                  ctl_i,
  input  logic signed [SampleW-1:0]  x_i,
  input  logic signed [WeightW-1:0]  w_i,
  input  logic signed [SampleW-1:0]  new_x_i,
  output logic signed [SampleW-1:0]  x_o,
  output logic signed [WeightW-1:0]  w_o
);
  logic signed [SampleW-1:0] x_q, x_d;
  logic signed [WeightW-1:0] w_q, w_d;

  // the updated head weight enters the ring at the tail through w_i
  always_comb begin
    x_d = x_q;
    w_d = w_q;
    if (ctl_i.clear) begin
      x_d = '0;
    end else if (ctl_i.shift_in) begin
      x_d = new_x_i;
    end else if (ctl_i.rotate) begin
      x_d = x_i;
      w_d = w_i;
    end else if (ctl_i.update) begin
      x_d = x_i;
      w_d = w_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_q <= '0;
      w_q <= '0;
    end else begin
      x_q <= x_d;
      w_q <= w_d;
    end
  end

  assign x_o = x_q;
  assign w_o = w_q;
endmodule

// File: sv/normalized_lms_predictor_unit.sv
// Normalized LMS predictor: cell chain of taps plus a shared sequenced datapath.
// While the window fills, an item goes straight to the result; with a full window
// the ring rotates to predict, and a trained item adds a 41-step restoring divide
// for alpha and an update pass. One item at a time; the next request is taken in
// the cycle after the result register loads; a stalled result holds the sequencer.
// Reset: window empty, weights zero, threshold 1.0, error sum zero, goal 3277.
`timescale 1ns / 1ps
module normalized_lms_predictor_unit
  import nlms_pkg::*;
#(
  parameter int unsigned TAPS = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // sample
  input  logic [1:0]  s_axis_tuser,   // train, epoch_start
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // prediction, pred_error, epoch_error
  output logic [1:0]  m_axis_tuser,   // pred_valid, goal_met
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data
);
  localparam int unsigned CntW = $clog2(TAPS + 1) + 1;

  state_e state_q, state_d;
  cell_ctl_t ctl;
  logic [CntW-1:0] fill_q, cnt_q;
  logic [5:0] dcnt_q;
  logic signed [SampleW-1:0] x_q;
  logic train_q;
  logic [31:0] goal_q, esum_q;
  logic signed [31:0] thr_q;
  logic signed [63:0] acc_q;
  logic [47:0] sq_q;
  logic [41:0] rem_q;
  logic [40:0] quo_q;
  logic signed [31:0] err_q;
  logic signed [15:0] pred_q;
  logic signed [48:0] ae_q;
  logic valid_q;

  logic signed [SampleW-1:0] xs [TAPS+1];
  logic signed [WeightW-1:0] ws [TAPS+1];
  logic signed [WeightW-1:0] new_w;

  genvar g;
  generate
    for (g = 0; g < TAPS; g++) begin : g_cell
      nlms_cell u_cell (
        .clk_i, .rst_ni, .ctl_i(ctl),
        .x_i(xs[g+1]), .w_i(ws[g+1]),
        .new_x_i((g == TAPS - 1) ? x_q : xs[g+1]),
        .x_o(xs[g]), .w_o(ws[g])
      );
    end
  endgenerate
  // ring: head (cell 0) feeds the tail
  assign xs[TAPS] = xs[0];
  assign ws[TAPS] = (state_q == ST_UPDATE) ? new_w : ws[0];

  // weight step for head cell
  logic signed [64:0] wd_prod;
  logic signed [64:0] wd_r;
  logic signed [36:0] w_sum;
  assign wd_prod = ae_q * xs[0];
  assign wd_r = (wd_prod + (65'sd1 <<< 27)) >>> 28;
  always_comb begin
    w_sum = 37'(ws[0]) - 37'(wd_r);
    if (w_sum > 37'sh7FFF_FFFF) new_w = 32'sh7FFF_FFFF;
    else if (w_sum < -37'sh8000_0000) new_w = 32'sh8000_0000;
    else new_w = w_sum[31:0];
  end

  // prediction path, evaluated on the last accumulate step
  logic signed [63:0] acc_n;
  logic signed [63:0] y24;
  logic signed [64:0] e_full;
  logic signed [31:0] err_sat;
  logic signed [15:0] pred_o, perr_o;
  logic signed [63:0] yr, er;
  assign acc_n = acc_q + 64'(ws[0]) * 64'(xs[0]);
  assign y24 = (acc_n - 64'(thr_q) * 64'sd4096 + 64'sd2048) >>> 12;
  assign e_full = 65'(y24) - 65'(x_q) * 65'sd4096;
  assign err_sat = (e_full > 65'sh7FFF_FFFF) ? 32'sh7FFF_FFFF :
                   (e_full < -65'sh8000_0000) ? 32'sh8000_0000 : e_full[31:0];
  assign yr = (y24 + 64'sd2048) >>> 12;
  assign er = (64'(err_q) + 64'sd2048) >>> 12;
  assign pred_o = (yr > 64'sd32767) ? 16'sh7FFF : (yr < -64'sd32768) ? 16'sh8000 : yr[15:0];
  assign perr_o = (er > 64'sd32767) ? 16'sh7FFF : (er < -64'sd32768) ? 16'sh8000 : er[15:0];

  // half squared error
  logic [63:0] sqe;
  logic [31:0] half;
  logic [32:0] esum_n;
  assign sqe = 64'(64'(err_q) * 64'(err_q));
  assign half = 32'((65'(sqe) + (65'd1 << 32)) >> 33);
  assign esum_n = 33'(esum_q) + 33'(half);

  // divider step: 2^40 / (2^24 + sq)
  logic [48:0] den;
  logic [49:0] trial;
  assign den = 49'(sq_q) + (49'd1 << 24);
  assign trial = {8'd0, rem_q} - 50'(den);

  logic [15:0] alpha;
  assign alpha = (quo_q > 41'd65535) ? 16'hFFFF : quo_q[15:0];

  logic s_acc, out_free;
  assign out_free = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign s_acc = s_axis_tvalid && s_axis_tready;
  assign cfg_ready = 1'b1;

  logic signed [31:0] sq_x;
  assign sq_x = xs[0] * xs[0];

  always_comb begin
    state_d = state_q;
    ctl = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (s_acc) begin
          ctl.clear = s_axis_tuser[1];
          state_d = ST_ROTATE;
        end
      end
      ST_ROTATE: begin
        if (fill_q < CntW'(TAPS)) state_d = ST_FINISH;
        else begin
          ctl.rotate = 1'b1;
          if (cnt_q == CntW'(TAPS - 1)) state_d = train_q ? ST_DIV : ST_FINISH;
        end
      end
      ST_DIV: if (dcnt_q == 6'd0) state_d = ST_UPDATE;
      ST_UPDATE: begin
        ctl.update = 1'b1;
        if (cnt_q == CntW'(TAPS - 1)) state_d = ST_FINISH;
      end
      ST_FINISH: if (out_free) state_d = ST_OUT;
      ST_OUT: begin
        ctl.shift_in = 1'b1;
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      fill_q <= '0;
      cnt_q <= '0;
      dcnt_q <= '0;
      goal_q <= GoalReset;
      esum_q <= '0;
      thr_q <= ThreshReset;
      m_axis_tvalid <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid) goal_q <= cfg_data;
      if (m_axis_tready && state_q != ST_OUT) m_axis_tvalid <= 1'b0;
      unique case (state_q)
        ST_IDLE: if (s_acc) begin
          cnt_q <= '0;
          if (s_axis_tuser[1]) begin
            fill_q <= '0;
            esum_q <= '0;
          end
        end
        ST_ROTATE: begin
          if (fill_q >= CntW'(TAPS)) cnt_q <= cnt_q + 1'b1;
          if (state_d == ST_DIV) dcnt_q <= 6'd40;
        end
        ST_DIV: begin
          dcnt_q <= dcnt_q - 1'b1;
          if (state_d == ST_UPDATE) cnt_q <= '0;
        end
        ST_UPDATE: begin
          cnt_q <= cnt_q + 1'b1;
          if (state_d == ST_FINISH) begin
            if (33'(thr_q) + 33'(ae_q >>> 16) + 33'((ae_q >>> 15) & 49'sd1)
                > 33'sh0_7FFF_FFFF) thr_q <= 32'sh7FFF_FFFF;
            else if (33'(thr_q) + 33'((ae_q + 49'sd32768) >>> 16) < -33'sh8000_0000)
              thr_q <= 32'sh8000_0000;
            else thr_q <= 32'(33'(thr_q) + 33'((ae_q + 49'sd32768) >>> 16));
          end
        end
        ST_FINISH: if (out_free && valid_q)
          esum_q <= esum_n[32] ? 32'hFFFF_FFFF : esum_n[31:0];
        ST_OUT: begin
          m_axis_tvalid <= 1'b1;
          if (fill_q < CntW'(TAPS)) fill_q <= fill_q + 1'b1;
        end
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: if (s_acc) begin
        x_q <= $signed(s_axis_tdata);
        train_q <= s_axis_tuser[0];
        acc_q <= '0;
        sq_q <= '0;
        valid_q <= 1'b0;
      end
      ST_ROTATE: begin
        if (fill_q >= CntW'(TAPS)) begin
          acc_q <= acc_n;
          sq_q <= sq_q + 48'(unsigned'(sq_x));
          valid_q <= 1'b1;
        end
        if (cnt_q == CntW'(TAPS - 1) || fill_q < CntW'(TAPS)) begin
          err_q <= err_sat;
          pred_q <= pred_o;
        end
        if (state_d == ST_DIV) begin
          rem_q <= 42'd1;
          quo_q <= '0;
        end
      end
      ST_DIV: begin
        // bit (dcnt) of dividend 2^40: bring down one bit per step
        if (!trial[49]) begin
          rem_q <= (dcnt_q == 6'd0) ? 42'(trial) : {trial[40:0], 1'b0};
          quo_q <= {quo_q[39:0], 1'b1};
        end else begin
          rem_q <= (dcnt_q == 6'd0) ? rem_q : {rem_q[40:0], 1'b0};
          quo_q <= {quo_q[39:0], 1'b0};
        end
        if (dcnt_q == 6'd0) ae_q <= 49'($signed({1'b0, alpha_next()})) * 49'(err_q);
      end
      default: ;
    endcase
  end

  function automatic logic [15:0] alpha_next();
    logic [40:0] qn;
    qn = {quo_q[39:0], !trial[49]};
    return (qn > 41'd65535) ? 16'hFFFF : qn[15:0];
  endfunction

  always_ff @(posedge clk_i) begin
    if (state_q == ST_OUT) begin
      m_axis_tdata <= valid_q ? {esum_q, perr_o, pred_q} : {esum_q, 32'd0};
      m_axis_tuser <= {esum_q < goal_q, valid_q};
    end
  end

  logic unused;
  assign unused = ^{alpha, ws[TAPS]};
endmodule

// File: bench/testbench.sv
// Self-checking bench for the normalized LMS predictor: directed and random samples.
`timescale 1ns / 1ps
module testbench
  import nlms_pkg::*;
;

  localparam int NTAPS = 4;
  localparam int CYCLE_LIMIT = 900000;

  typedef struct packed {
    logic signed [15:0] sample;
    logic               train;
    logic               epoch_start;
  } sample_req_t;

  typedef struct packed {
    logic signed [15:0] prediction;
    logic signed [15:0] pred_error;
    logic [31:0]        epoch_error;
    logic               pred_valid;
    logic               goal_met;
  } pred_res_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [63:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [31:0] cfg_data = '0;

  normalized_lms_predictor_unit #(.TAPS(NTAPS)) dut (.*);

  // predictor state
  logic signed [15:0] win_q [NTAPS];
  int unsigned        fill_q;
  logic signed [31:0] wts_q [NTAPS];
  logic signed [31:0] thresh_q;
  logic [31:0]        esum_q;
  logic [31:0]        goal_q;

  sample_req_t pending_q[$];
  pred_res_t   expected_q[$];
  int unsigned accepted_cnt = 0;
  int unsigned queued_cnt = 0;
  int unsigned fail_cnt = 0;
  longint      cycle_cnt = 0;
  bit          calm = 1'b0;
  int          hold_cycles = 0;
  logic        s_axis_tready_seen = 1'b0;

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  function automatic longint rnd_sh(longint v, int s);
    return (v + (longint'(1) << (s - 1))) >>> s;
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic pred_res_t predict_step(sample_req_t r);
    pred_res_t res;
    longint acc, y24, err24, ae, d, pred, perr, sum;
    longint unsigned sq, alpha, half;
    res = '0;
    pred = 0;
    perr = 0;
    if (r.epoch_start) begin
      foreach (win_q[j]) win_q[j] = '0;
      fill_q = 0;
      esum_q = '0;
    end
    if (fill_q >= NTAPS) begin
      acc = 0;
      foreach (wts_q[j]) acc += longint'(wts_q[j]) * longint'(win_q[j]);
      acc -= longint'(thresh_q) * 4096;
      y24 = rnd_sh(acc, 12);
      err24 = clip(y24 - longint'(r.sample) * 4096, -64'sd2147483648, 64'sd2147483647);
      pred = clip(rnd_sh(y24, 12), -32768, 32767);
      perr = clip(rnd_sh(err24, 12), -32768, 32767);
      if (r.train) begin
        sq = 0;
        foreach (win_q[j]) sq += longint'(win_q[j]) * longint'(win_q[j]);
        alpha = (64'd1 << 40) / ((64'd1 << 24) + sq);
        if (alpha > 65535) alpha = 65535;
        ae = longint'(alpha) * err24;
        foreach (wts_q[j]) begin
          d = rnd_sh(ae * longint'(win_q[j]), 28);
          wts_q[j] = 32'(clip(longint'(wts_q[j]) - d, -64'sd2147483648, 64'sd2147483647));
        end
        thresh_q = 32'(clip(longint'(thresh_q) + rnd_sh(ae, 16),
                            -64'sd2147483648, 64'sd2147483647));
      end
      half = longint'(err24 * err24);
      half = (half + (64'd1 << 32)) >> 33;
      sum = longint'(esum_q) + longint'(half);
      esum_q = sum > 64'hFFFF_FFFF ? 32'hFFFF_FFFF : 32'(sum);
      res.pred_valid = 1'b1;
    end
    for (int j = 0; j + 1 < NTAPS; j++) win_q[j] = win_q[j + 1];
    win_q[NTAPS - 1] = r.sample;
    if (fill_q < NTAPS) fill_q++;
    res.prediction = 16'(pred);
    res.pred_error = 16'(perr);
    res.epoch_error = esum_q;
    res.goal_met = esum_q < goal_q;
    return res;
  endfunction

  task automatic push_sample(logic signed [15:0] s, logic tr, logic st);
    sample_req_t r;
    r.sample = s;
    r.train = tr;
    r.epoch_start = st;
    pending_q.push_back(r);
    queued_cnt++;
  endtask

  task automatic write_goal(logic [31:0] v);
    @(negedge clk_i);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk_i); while (!cfg_ready);
    goal_q = v;
    @(negedge clk_i);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    while (accepted_cnt < queued_cnt || expected_q.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  // small random sample, mostly well-conditioned so training converges
  function automatic logic signed [15:0] rand_sample();
    int k;
    k = $urandom_range(0, 9);
    if (k == 0) return 16'($urandom);
    if (k == 1) return ($urandom_range(0, 1) ? 16'sh7fff : -16'sh8000);
    return 16'($signed($urandom_range(0, 8191)) - 4096);
  endfunction

  // driver: request offered from pending queue, random gaps
  int drv_gap = 0;
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!s_axis_tvalid || s_axis_tready_seen) begin
        if (drv_gap > 0) begin
          drv_gap <= drv_gap - 1;
          s_axis_tvalid <= 1'b0;
        end else if (pending_q.size() != 0) begin
          sample_req_t r;
          r = pending_q.pop_front();
          s_axis_tdata <= r.sample;
          s_axis_tuser <= {r.epoch_start, r.train};
          s_axis_tvalid <= 1'b1;
          if (!calm && $urandom_range(0, 5) == 0) drv_gap <= $urandom_range(1, 8);
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    s_axis_tready_seen <= s_axis_tvalid && s_axis_tready;
    if (s_axis_tvalid && s_axis_tready) begin
      sample_req_t r;
      r.sample = s_axis_tdata;
      r.train = s_axis_tuser[0];
      r.epoch_start = s_axis_tuser[1];
      expected_q.push_back(predict_step(r));
      accepted_cnt++;
    end
  end

  // receiver: random stalls plus long hold-offs on request
  int rcv_gap = 0;
  always @(negedge clk_i) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      m_axis_tready <= 1'b0;
    end else if (rcv_gap > 0) begin
      rcv_gap <= rcv_gap - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
      if (!calm && $urandom_range(0, 5) == 0) rcv_gap <= $urandom_range(1, 8);
    end
  end

  // monitor
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      pred_res_t want, got;
      got.prediction = m_axis_tdata[15:0];
      got.pred_error = m_axis_tdata[31:16];
      got.epoch_error = m_axis_tdata[63:32];
      got.pred_valid = m_axis_tuser[0];
      got.goal_met = m_axis_tuser[1];
      if (expected_q.size() == 0) begin
        $error("result with nothing expected");
        fail_cnt++;
      end else begin
        want = expected_q.pop_front();
        if (got.prediction !== want.prediction) begin
          $error("prediction exp %0d got %0d", want.prediction, got.prediction);
          fail_cnt++;
        end
        if (got.pred_error !== want.pred_error) begin
          $error("pred_error exp %0d got %0d", want.pred_error, got.pred_error);
          fail_cnt++;
        end
        if (got.epoch_error !== want.epoch_error) begin
          $error("epoch_error exp %0h got %0h", want.epoch_error, got.epoch_error);
          fail_cnt++;
        end
        if (got.pred_valid !== want.pred_valid) begin
          $error("pred_valid exp %0b got %0b", want.pred_valid, got.pred_valid);
          fail_cnt++;
        end
        if (got.goal_met !== want.goal_met) begin
          $error("goal_met exp %0b got %0b", want.goal_met, got.goal_met);
          fail_cnt++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    int seq_len;
    foreach (win_q[j]) begin
      win_q[j] = '0;
      wts_q[j] = '0;
    end
    fill_q = 0;
    thresh_q = ThreshReset;
    esum_q = '0;
    goal_q = GoalReset;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: fill, extremes, train on partial window, epoch restart
    push_sample(16'sh7fff, 1'b1, 1'b0);
    push_sample(-16'sh8000, 1'b1, 1'b0);
    push_sample(16'sh0000, 1'b0, 1'b0);
    push_sample(16'sh1000, 1'b0, 1'b0);
    push_sample(16'sh7fff, 1'b0, 1'b0);
    push_sample(-16'sh8000, 1'b1, 1'b0);
    push_sample(16'sh7fff, 1'b1, 1'b0);
    push_sample(-16'sh8000, 1'b1, 1'b0);
    push_sample(16'sh7fff, 1'b1, 1'b0);
    push_sample(16'sh0000, 1'b1, 1'b1);
    for (int i = 0; i < 4; i++) push_sample(16'sh0000, 1'b1, 1'b0);
    push_sample(16'sh0800, 1'b1, 1'b0);
    push_sample(-16'sh0800, 1'b0, 1'b0);
    push_sample(16'shffff, 1'b1, 1'b0);
    push_sample(16'sh5555, 1'b1, 1'b0);
    push_sample(-16'sh5556, 1'b1, 1'b0);
    drain();

    write_goal(32'hFFFF_FFFF);
    // long receiver hold-off while the sender keeps offering
    hold_cycles = 400;
    for (int i = 0; i < 30; i++) push_sample(rand_sample(), 1'($urandom), 1'b0);
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: write_goal(32'd0);
        1: write_goal(32'($urandom));
        2: write_goal(32'd3277);
        default: write_goal(32'd1 << $urandom_range(8, 24));
      endcase
      if (ph == 3) calm = 1'b1;
      for (int i = 0; i < 425; i += seq_len) begin
        seq_len = $urandom_range(6, 40);
        push_sample(rand_sample(), $urandom_range(0, 7) != 0, $urandom_range(0, 3) == 0);
        for (int k = 1; k < seq_len; k++) begin
          if ($urandom_range(0, 19) == 0)
            push_sample(16'($urandom), 1'($urandom), 1'($urandom));
          else
            push_sample(rand_sample(), $urandom_range(0, 4) != 0, 1'b0);
        end
        while (pending_q.size() > 20) @(posedge clk_i);
      end
      drain();
    end

    if (fail_cnt == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule

// File: normalized_lms_predictor_unit.f
sv/nlms_pkg.sv
sv/nlms_cell.sv
sv/normalized_lms_predictor_unit.sv
bench/testbench.sv
